### design/smx_pkg.sv
`default_nettype none
package smx_pkg;
    localparam int STACK_DEPTH  = 256;
    localparam int GLOBAL_COUNT = 16;
    localparam int LOCAL_COUNT  = 16;
    localparam int CALL_DEPTH   = 64;
    localparam int ADDR_BITS    = 16;
    localparam int SP_BITS      = $clog2(STACK_DEPTH);
    localparam int SC_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int GI_BITS      = (GLOBAL_COUNT > 1) ? $clog2(GLOBAL_COUNT) : 1;
    localparam int LI_BITS      = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
    localparam int FP_BITS      = $clog2(CALL_DEPTH);
    localparam int FC_BITS      = $clog2(CALL_DEPTH + 1);
    localparam int LA_BITS      = $clog2(CALL_DEPTH * LOCAL_COUNT);
    localparam int LOCAL_WORDS  = CALL_DEPTH * LOCAL_COUNT;

    typedef enum logic [5:0] {
        OP_NOP, OP_DUMP, OP_TRACE, OP_PRINT, OP_HALT, OP_FATAL, OP_CONST, OP_POP,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_ABS, OP_NEG, OP_EQ, OP_NEQ,
        OP_GT, OP_LT, OP_GTE, OP_LTE, OP_JMP, OP_RJMP, OP_JMPI, OP_RJMPI, OP_JZ,
        OP_JNZ, OP_GSTORE, OP_GLOAD, OP_CALL, OP_RET, OP_STORE, OP_LOAD
    } opcode_t;

    typedef enum logic [2:0] {
        ST_RUN, ST_HALT, ST_END, ST_FATAL, ST_STACK, ST_DIVZ, ST_DEPTH, ST_INDEX
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch item, issue stack reads
        logic execute;   // operands ready: decide and commit
        logic div_start;
        logic finish;    // division done: commit
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

### design/smx_ram.sv
`default_nettype none
module smx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/smx_div.sv
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle.
module smx_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic      [31:0] quotient,
    output logic      [31:0] remainder
);
    logic [5:0]  count_reg;
    logic        busy_reg;
    logic [31:0] q_reg, r_reg, d_reg;
    logic [32:0] trial;

    assign trial     = {r_reg, q_reg[31]} - {1'b0, d_reg};
    assign quotient  = q_reg;
    assign remainder = r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done      <= 1'b0;
            count_reg <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                count_reg <= 6'd32;
            end else if (busy_reg) begin
                count_reg <= count_reg - 6'd1;
                if (count_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // shift/subtract step
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end else begin
                r_reg <= {r_reg[30:0], q_reg[31]};
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

### design/smx_ctrl.sv
`default_nettype none
module smx_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output smx_pkg::cmd_t      cmd,
    input  wire smx_pkg::stat_t stat
);
    import smx_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_DIVW, S_OUT} state_t;
    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb begin
        cmd           = '0;
        cmd.capture   = in_valid && in_ready;
        cmd.execute   = (state_reg == S_READ) && !stat.need_div;
        cmd.div_start = (state_reg == S_READ) && stat.need_div;
        cmd.finish    = (state_reg == S_DIVW) && stat.div_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_READ;
                S_READ: state_reg <= stat.need_div ? S_DIVW : S_OUT;
                S_DIVW: if (stat.div_done) state_reg <= S_OUT;
                S_OUT:  if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.capture, cmd.execute, cmd.div_start, cmd.finish}) <= 1)
        else $error("overlapping datapath commands");
    a_read_follows_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == S_READ))
        else $error("capture not followed by operand read");
    a_out_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid) |-> ($past(cmd.execute) || $past(cmd.finish)))
        else $error("result without commit");
endmodule
`default_nettype wire

### design/smx_datapath.sv
`default_nettype none
module smx_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire smx_pkg::cmd_t               cmd,
    output smx_pkg::stat_t                   stat,
    input  wire logic [5:0]                  in_kind,
    input  wire logic [31:0]                 in_operand,
    input  wire logic                        cfg_we,
    input  wire logic [15:0]                 cfg_data,
    output logic      [15:0]                 res_next_address,
    output logic                             res_print_valid,
    output logic      [31:0]                 res_print_value,
    output logic                             res_trace,
    output logic      [2:0]                  res_status
);
    import smx_pkg::*;

    logic [15:0]          plen_reg;
    logic [5:0]           kind_reg;
    logic [31:0]          opnd_reg;
    logic [SC_BITS-1:0]   sc_reg;
    logic [FC_BITS-1:0]   fc_reg;
    logic [ADDR_BITS-1:0] ip_reg;
    logic                 trace_reg, stopped_reg;
    logic [2:0]           stop_code_reg;
    logic [31:0]          glob_reg [GLOBAL_COUNT];

    // memories: two stack read ports via two copies
    logic                 st_we;
    logic [SP_BITS-1:0]   st_waddr;
    logic [31:0]          st_wdata, top_q, sec_q, loc_q;
    logic [SP_BITS-1:0]   top_addr, sec_addr;
    logic [15:0]          ret_q;
    logic                 ret_we, loc_we;
    logic [LA_BITS-1:0]   loc_addr;
    logic [FP_BITS-1:0]   ret_raddr;
    // per-frame written mask of the locals, cleared by CALL
    logic                   lwm_we;
    logic [FP_BITS-1:0]     lwm_waddr;
    logic [LOCAL_COUNT-1:0] lwm_wdata, lwm_q;

    assign top_addr  = SP_BITS'(sc_reg - SC_BITS'(1));
    assign sec_addr  = SP_BITS'(sc_reg - SC_BITS'(2));
    assign ret_raddr = FP_BITS'(fc_reg - FC_BITS'(1));
    assign loc_addr  = LA_BITS'((fc_reg - FC_BITS'(1)) * LOCAL_COUNT)
                     + LA_BITS'(opnd_reg[LI_BITS-1:0]);

    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk_a (
        .aclk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(top_addr), .rdata(top_q));
    smx_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk_b (
        .aclk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(sec_addr), .rdata(sec_q));
    smx_ram #(.WIDTH(16), .DEPTH(CALL_DEPTH)) u_ret (
        .aclk, .we(ret_we), .waddr(FP_BITS'(fc_reg)),
        .wdata(16'(ip_reg + ADDR_BITS'(2))), .raddr(ret_raddr), .rdata(ret_q));
    smx_ram #(.WIDTH(32), .DEPTH(LOCAL_WORDS)) u_loc (
        .aclk, .we(loc_we), .waddr(loc_addr), .wdata(top_q),
        .raddr(LA_BITS'((fc_reg - FC_BITS'(1)) * LOCAL_COUNT)
               + LA_BITS'(in_operand[LI_BITS-1:0])), .rdata(loc_q));
    smx_ram #(.WIDTH(LOCAL_COUNT), .DEPTH(CALL_DEPTH)) u_lwm (
        .aclk, .we(lwm_we), .waddr(lwm_waddr), .wdata(lwm_wdata),
        .raddr(ret_raddr), .rdata(lwm_q));

    // divider on magnitudes
    logic [31:0] mag_l, mag_r, dq, dr;
    logic        div_done;
    assign mag_l = sec_q[31] ? -sec_q : sec_q;
    assign mag_r = top_q[31] ? -top_q : top_q;
    smx_div u_div (.aclk, .aresetn, .start(cmd.div_start), .dividend(mag_l),
        .divisor(mag_r), .done(div_done), .quotient(dq), .remainder(dr));

    logic is_div, run;
    assign is_div = (kind_reg == OP_DIV || kind_reg == OP_MOD);
    assign run    = !stopped_reg && (ip_reg != plen_reg[ADDR_BITS-1:0]);
    assign stat.need_div = run && is_div && sc_reg >= SC_BITS'(2) && top_q != 0;
    assign stat.div_done = div_done;

    logic lt_lr, lt_rl;
    assign lt_lr = $signed(sec_q) < $signed(top_q);
    assign lt_rl = $signed(top_q) < $signed(sec_q);

    // decode and effect of one instruction
    logic [2:0]           st;
    logic [ADDR_BITS-1:0] nxt;
    logic                 pv, do_push, do_pop1, do_pop2, do_rw, tog, g_we, l_we;
    logic                 c_we, r_ret;
    logic [31:0]          res, mulv, qv, rv;
    logic                 g_ok, l_ok, empty, full;
    logic [ADDR_BITS-1:0] ip1, ip2;

    assign mulv = sec_q * top_q;
    assign qv   = (sec_q[31] ^ top_q[31]) ? -dq : dq;
    assign rv   = sec_q[31] ? -dr : dr;
    assign g_ok = opnd_reg < 32'(GLOBAL_COUNT);
    assign l_ok = opnd_reg < 32'(LOCAL_COUNT);
    assign empty = sc_reg == '0;
    assign full  = sc_reg >= SC_BITS'(STACK_DEPTH);
    assign ip1 = ip_reg + ADDR_BITS'(1);
    assign ip2 = ip_reg + ADDR_BITS'(2);

    always_comb begin
        st = ST_RUN; nxt = ip1; pv = 1'b0; do_push = 1'b0; do_pop1 = 1'b0;
        do_pop2 = 1'b0; do_rw = 1'b0; tog = 1'b0; g_we = 1'b0; l_we = 1'b0;
        c_we = 1'b0; r_ret = 1'b0; res = top_q;
        unique case (kind_reg)
            OP_NOP, OP_DUMP: ;
            OP_TRACE: tog = 1'b1;
            OP_PRINT: if (empty) st = ST_STACK; else begin pv = 1'b1; do_pop1 = 1'b1; end
            OP_HALT: st = ST_HALT;
            OP_CONST: if (full) st = ST_STACK;
                      else begin do_push = 1'b1; res = opnd_reg; nxt = ip2; end
            OP_POP: if (empty) st = ST_STACK; else do_pop1 = 1'b1;
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NEQ,
            OP_GT, OP_LT, OP_GTE, OP_LTE: begin
                if (sc_reg < SC_BITS'(2)) st = ST_STACK;
                else if (is_div && top_q == 0) st = ST_DIVZ;
                else begin
                    do_pop2 = 1'b1;
                    unique case (kind_reg)
                        OP_ADD: res = sec_q + top_q;
                        OP_SUB: res = sec_q - top_q;
                        OP_MUL: res = mulv;
                        OP_DIV: res = qv;
                        OP_MOD: res = rv;
                        OP_EQ:  res = 32'(sec_q == top_q);
                        OP_NEQ: res = 32'(sec_q != top_q);
                        OP_GT:  res = 32'(lt_rl);
                        OP_LT:  res = 32'(lt_lr);
                        OP_GTE: res = 32'(!lt_lr);
                        default: res = 32'(!lt_rl);
                    endcase
                end
            end
            OP_ABS, OP_NEG: if (empty) st = ST_STACK; else begin
                do_rw = 1'b1;
                res = (kind_reg == OP_NEG || top_q[31]) ? -top_q : top_q;
            end
            OP_JMP:  nxt = opnd_reg[ADDR_BITS-1:0];
            OP_RJMP: nxt = ip_reg + opnd_reg[ADDR_BITS-1:0];
            OP_JMPI, OP_RJMPI: if (empty) st = ST_STACK; else begin
                do_pop1 = 1'b1;
                nxt = (kind_reg == OP_JMPI) ? top_q[ADDR_BITS-1:0]
                                            : ip_reg + top_q[ADDR_BITS-1:0];
            end
            OP_JZ, OP_JNZ: if (empty) st = ST_STACK; else begin
                do_pop1 = 1'b1;
                nxt = ((top_q == 0) == (kind_reg == OP_JZ)) ? opnd_reg[ADDR_BITS-1:0] : ip2;
            end
            OP_GSTORE: if (!g_ok) st = ST_INDEX; else if (empty) st = ST_STACK;
                       else begin g_we = 1'b1; do_pop1 = 1'b1; nxt = ip2; end
            OP_GLOAD: if (!g_ok) st = ST_INDEX; else if (full) st = ST_STACK;
                      else begin do_push = 1'b1; res = glob_reg[opnd_reg[GI_BITS-1:0]];
                          nxt = ip2; end
            OP_CALL: if (fc_reg >= FC_BITS'(CALL_DEPTH)) st = ST_DEPTH;
                     else begin c_we = 1'b1; nxt = opnd_reg[ADDR_BITS-1:0]; end
            OP_RET: if (fc_reg == '0) st = ST_DEPTH;
                    else begin r_ret = 1'b1; nxt = ret_q[ADDR_BITS-1:0]; end
            OP_STORE: if (fc_reg == '0) st = ST_DEPTH; else if (!l_ok) st = ST_INDEX;
                      else if (empty) st = ST_STACK;
                      else begin l_we = 1'b1; do_pop1 = 1'b1; nxt = ip2; end
            OP_LOAD: if (fc_reg == '0) st = ST_DEPTH; else if (!l_ok) st = ST_INDEX;
                     else if (full) st = ST_STACK;
                     else begin do_push = 1'b1; nxt = ip2;
                         res = lwm_q[opnd_reg[LI_BITS-1:0]] ? loc_q : '0; end
            default: st = ST_FATAL;
        endcase
        if (st != ST_RUN) begin
            nxt = ip_reg; pv = 1'b0; do_push = 1'b0; do_pop1 = 1'b0; do_pop2 = 1'b0;
            do_rw = 1'b0; tog = 1'b0; g_we = 1'b0; l_we = 1'b0; c_we = 1'b0; r_ret = 1'b0;
        end else if (nxt == plen_reg[ADDR_BITS-1:0]) begin
            st = ST_END;
        end
    end

    logic commit;
    assign commit   = (cmd.execute || cmd.finish) && run;
    assign st_we    = commit && (do_push || do_pop2 || do_rw);
    assign st_waddr = do_push ? SP_BITS'(sc_reg) : do_pop2 ? sec_addr : top_addr;
    assign st_wdata = res;
    assign ret_we   = commit && c_we;
    assign loc_we   = commit && l_we;

    // written mask: CALL clears the new frame, STORE sets one bit of the top frame
    assign lwm_we    = commit && (c_we || l_we);
    assign lwm_waddr = c_we ? FP_BITS'(fc_reg) : ret_raddr;
    assign lwm_wdata = c_we ? '0
                     : (lwm_q | (LOCAL_COUNT'(1) << opnd_reg[LI_BITS-1:0]));

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= in_kind;
            opnd_reg <= in_operand;
        end
        if (commit && g_we) glob_reg[opnd_reg[GI_BITS-1:0]] <= top_q;
        if (!aresetn) begin
            for (int i = 0; i < GLOBAL_COUNT; i++) glob_reg[i] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0; sc_reg <= '0; fc_reg <= '0; ip_reg <= '0;
            trace_reg <= 1'b0; stopped_reg <= 1'b0; stop_code_reg <= ST_RUN;
            res_next_address <= '0; res_print_valid <= 1'b0; res_print_value <= '0;
            res_trace <= 1'b0; res_status <= ST_RUN;
        end else begin
            if (cfg_we) plen_reg <= cfg_data;
            if (cmd.execute || cmd.finish) begin
                if (!run) begin
                    stopped_reg <= 1'b1;
                    if (!stopped_reg) stop_code_reg <= ST_END;
                    res_next_address <= 16'(ip_reg);
                    res_print_valid  <= 1'b0;
                    res_print_value  <= '0;
                    res_trace        <= trace_reg;
                    res_status       <= stopped_reg ? stop_code_reg : ST_END;
                end else begin
                    if (do_push) sc_reg <= sc_reg + SC_BITS'(1);
                    if (do_pop1 || do_pop2) sc_reg <= sc_reg - SC_BITS'(1);
                    if (c_we) fc_reg <= fc_reg + FC_BITS'(1);
                    if (r_ret) fc_reg <= fc_reg - FC_BITS'(1);
                    if (tog) trace_reg <= !trace_reg;
                    ip_reg <= nxt;
                    if (st != ST_RUN) begin
                        stopped_reg <= 1'b1;
                        stop_code_reg <= st;
                    end
                    res_next_address <= 16'(nxt);
                    res_print_valid  <= pv;
                    res_print_value  <= pv ? top_q : '0;
                    res_trace        <= trace_reg ^ tog;
                    res_status       <= st;
                end
            end
        end
    end

    a_stopped_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (stopped_reg && !cfg_we) |=> ($stable(ip_reg) && $stable(sc_reg)))
        else $error("state moved while stopped");
    a_sc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_reg <= SC_BITS'(STACK_DEPTH))
        else $error("stack count out of range");
    a_fault_holds_ip: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && st != ST_RUN && st != ST_END) |=> $stable(ip_reg))
        else $error("fault moved address");
endmodule
`default_nettype wire

### design/stack_machine_executor_unit.sv
`default_nettype none
// Stack-machine executor: one instruction per input transfer (opcode in
// s_tuser, following code word in s_tdata), one result per transfer. An
// item goes through the accept cycle (capture and registered stack-memory
// read), the commit state and the result state, in which the result is
// valid and held until its handshake. DIV and MOD wait in the bit-serial
// divider between the read and the commit state. The operand stack,
// call-return stack, local frames and the per-frame local-written masks live
// in RAM; CALL clears the mask of the new frame, so no clearing pass is
// needed after reset. Globals are flip-flops. After a stop status the block
// keeps answering with the held status until reset.
module stack_machine_executor_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // operand[31:0]
    input  wire logic [5:0]  s_tuser,   // kind[5:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // next_address[15:0], print_value[47:16], status[50:48]
    output logic [1:0]       m_tuser,   // print_valid[0], trace_enabled[1]
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data
);
    import smx_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic [15:0] na;
    logic [31:0] pval;
    logic        pv, tr;
    logic [2:0]  sts;

    smx_ctrl u_ctrl (.aclk, .aresetn, .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd, .stat);

    smx_datapath u_dp (.aclk, .aresetn, .cmd, .stat, .in_kind(s_tuser),
        .in_operand(s_tdata), .cfg_we, .cfg_data, .res_next_address(na),
        .res_print_valid(pv), .res_print_value(pval), .res_trace(tr),
        .res_status(sts));

    assign m_tdata = {5'd0, sts, pval, na};
    assign m_tuser = {tr, pv};
endmodule
`default_nettype wire

### dv/smx_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the config port, predicts every result of the
// executor and compares it field by field with what the block delivers.
module smx_checker
    import smx_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [5:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    output int               fail_count,
    output int               pending,
    output int               stack_depth,
    output int               frame_depth,
    output logic [15:0]      pc,
    output logic [31:0]      top_value
);

    typedef struct packed {
        logic [15:0] addr;
        logic        pv;
        logic [31:0] pval;
        logic        trace;
        status_t     st;
    } step_result_t;

    // machine state mirror
    logic [31:0]          stk [STACK_DEPTH];
    int                   sc;
    logic [31:0]          glob [GLOBAL_COUNT];
    logic [31:0]          loc [LOCAL_WORDS];
    logic                 lw [LOCAL_WORDS];
    logic [ADDR_BITS-1:0] rets [CALL_DEPTH];
    int                   fc;
    logic [ADDR_BITS-1:0] ip;
    logic                 trace_on;
    logic                 stopped;
    status_t              stop_code;
    logic [15:0]          plen;

    step_result_t expected_results [$];

    function automatic logic [31:0] mag(input logic [31:0] a);
        return a[31] ? (32'd0 - a) : a;
    endfunction

    function automatic logic [31:0] alu_result(input logic [5:0] k,
                                               input logic [31:0] l, input logic [31:0] r);
        logic [31:0] q;
        case (k)
            OP_ADD: return l + r;
            OP_SUB: return l - r;
            OP_MUL: return l * r;
            OP_DIV: begin
                q = mag(l) / mag(r);
                return (l[31] ^ r[31]) ? (32'd0 - q) : q;
            end
            OP_MOD: begin
                q = mag(l) % mag(r);
                return l[31] ? (32'd0 - q) : q;
            end
            OP_EQ:  return {31'd0, l == r};
            OP_NEQ: return {31'd0, l != r};
            OP_GT:  return {31'd0, $signed(l) > $signed(r)};
            OP_LT:  return {31'd0, $signed(l) < $signed(r)};
            OP_GTE: return {31'd0, $signed(l) >= $signed(r)};
            default: return {31'd0, $signed(l) <= $signed(r)};
        endcase
    endfunction

    task automatic execute_instr(input logic [5:0] k, input logic [31:0] op,
                                 output step_result_t r);
        logic [31:0] nxt;
        logic [31:0] v;
        int          base;
        status_t     st;
        logic        pv;
        logic [31:0] pval;
        nxt  = {16'd0, ip};
        st   = ST_RUN;
        pv   = 1'b0;
        pval = '0;
        if (!stopped && ip == plen) begin
            stopped   = 1'b1;
            stop_code = ST_END;
        end
        if (stopped) begin
            r = '{ip, 1'b0, 32'd0, trace_on, stop_code};
        end else begin
            case (k)
                OP_NOP, OP_DUMP: nxt = ip + 1;
                OP_TRACE: begin
                    trace_on = !trace_on;
                    nxt = ip + 1;
                end
                OP_PRINT: begin
                    if (sc == 0) st = ST_STACK;
                    else begin
                        sc--;
                        pval = stk[sc];
                        pv = 1'b1;
                        nxt = ip + 1;
                    end
                end
                OP_HALT: st = ST_HALT;
                OP_CONST: begin
                    if (sc >= STACK_DEPTH) st = ST_STACK;
                    else begin
                        stk[sc] = op;
                        sc++;
                        nxt = ip + 2;
                    end
                end
                OP_POP: begin
                    if (sc == 0) st = ST_STACK;
                    else begin
                        sc--;
                        nxt = ip + 1;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_EQ, OP_NEQ,
                OP_GT, OP_LT, OP_GTE, OP_LTE: begin
                    if (sc < 2) st = ST_STACK;
                    else if ((k == OP_DIV || k == OP_MOD) && stk[sc-1] == 0) st = ST_DIVZ;
                    else begin
                        v = alu_result(k, stk[sc-2], stk[sc-1]);
                        sc--;
                        stk[sc-1] = v;
                        nxt = ip + 1;
                    end
                end
                OP_ABS, OP_NEG: begin
                    if (sc == 0) st = ST_STACK;
                    else begin
                        v = stk[sc-1];
                        stk[sc-1] = (k == OP_ABS) ? mag(v) : (32'd0 - v);
                        nxt = ip + 1;
                    end
                end
                OP_JMP:  nxt = op;
                OP_RJMP: nxt = ip + op;
                OP_JMPI, OP_RJMPI: begin
                    if (sc == 0) st = ST_STACK;
                    else begin
                        sc--;
                        v = stk[sc];
                        nxt = (k == OP_JMPI) ? v : (ip + v);
                    end
                end
                OP_JZ, OP_JNZ: begin
                    if (sc == 0) st = ST_STACK;
                    else begin
                        sc--;
                        v = stk[sc];
                        nxt = ((v == 0) == (k == OP_JZ)) ? op : (ip + 2);
                    end
                end
                OP_GSTORE: begin
                    if (op >= GLOBAL_COUNT) st = ST_INDEX;
                    else if (sc == 0) st = ST_STACK;
                    else begin
                        sc--;
                        glob[op[GI_BITS-1:0]] = stk[sc];
                        nxt = ip + 2;
                    end
                end
                OP_GLOAD: begin
                    if (op >= GLOBAL_COUNT) st = ST_INDEX;
                    else if (sc >= STACK_DEPTH) st = ST_STACK;
                    else begin
                        stk[sc] = glob[op[GI_BITS-1:0]];
                        sc++;
                        nxt = ip + 2;
                    end
                end
                OP_CALL: begin
                    if (fc >= CALL_DEPTH) st = ST_DEPTH;
                    else begin
                        rets[fc] = ip + 16'd2;
                        for (int i = 0; i < LOCAL_COUNT; i++) lw[fc*LOCAL_COUNT + i] = 1'b0;
                        fc++;
                        nxt = op;
                    end
                end
                OP_RET: begin
                    if (fc == 0) st = ST_DEPTH;
                    else begin
                        fc--;
                        nxt = {16'd0, rets[fc]};
                    end
                end
                OP_STORE, OP_LOAD: begin
                    if (fc == 0) st = ST_DEPTH;
                    else if (op >= LOCAL_COUNT) st = ST_INDEX;
                    else begin
                        base = (fc - 1) * LOCAL_COUNT + int'(op);
                        if (k == OP_STORE) begin
                            if (sc == 0) st = ST_STACK;
                            else begin
                                sc--;
                                loc[base] = stk[sc];
                                lw[base] = 1'b1;
                            end
                        end else begin
                            if (sc >= STACK_DEPTH) st = ST_STACK;
                            else begin
                                stk[sc] = lw[base] ? loc[base] : 32'd0;
                                sc++;
                            end
                        end
                        nxt = ip + 2;
                    end
                end
                // FATAL and every unassigned opcode
                default: st = ST_FATAL;
            endcase
            nxt = nxt & 32'h0000_FFFF;
            if (st != ST_RUN) nxt = {16'd0, ip};
            else if (nxt[15:0] == plen) st = ST_END;
            ip = nxt[15:0];
            if (st != ST_RUN) begin
                stopped   = 1'b1;
                stop_code = st;
            end
            r = '{nxt[15:0], pv, pval, trace_on, st};
        end
    endtask

    always @(posedge aclk) begin
        step_result_t exp_r;
        step_result_t got;
        if (!aresetn) begin
            sc        = 0;
            fc        = 0;
            ip        = '0;
            trace_on  = 1'b0;
            stopped   = 1'b0;
            stop_code = ST_RUN;
            plen      = '0;
            for (int i = 0; i < GLOBAL_COUNT; i++) glob[i] = '0;
            for (int i = 0; i < LOCAL_WORDS; i++) lw[i] = 1'b0;
            expected_results.delete();
            fail_count = 0;
        end else begin
            // result channel
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[15:0], m_tuser[0], m_tdata[47:16], m_tuser[1],
                        status_t'(m_tdata[50:48])};
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transfer %h", $realtime, got);
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.addr != exp_r.addr) begin
                        $display("%0t: next_address expected %h actual %h",
                                 $realtime, exp_r.addr, got.addr);
                        fail_count++;
                    end
                    if (got.pv != exp_r.pv) begin
                        $display("%0t: print_valid expected %b actual %b",
                                 $realtime, exp_r.pv, got.pv);
                        fail_count++;
                    end
                    if (got.pval != exp_r.pval) begin
                        $display("%0t: print_value expected %h actual %h",
                                 $realtime, exp_r.pval, got.pval);
                        fail_count++;
                    end
                    if (got.trace != exp_r.trace) begin
                        $display("%0t: trace_enabled expected %b actual %b",
                                 $realtime, exp_r.trace, got.trace);
                        fail_count++;
                    end
                    if (got.st != exp_r.st) begin
                        $display("%0t: status expected %s actual %s",
                                 $realtime, exp_r.st.name(), got.st.name());
                        fail_count++;
                    end
                end
            end
            // instruction channel
            if (s_tvalid && s_tready) begin
                execute_instr(s_tuser, s_tdata, exp_r);
                expected_results.push_back(exp_r);
            end
            if (cfg_we) plen = cfg_data;
        end
        pending     = expected_results.size();
        stack_depth = sc;
        frame_depth = fc;
        pc          = ip;
        top_value   = (sc > 0) ? stk[sc-1] : 32'd0;
    end

endmodule

### dv/tb_stack_machine_executor_unit.sv
`timescale 1ns / 1ps
module tb_stack_machine_executor_unit;
    import smx_pkg::*;

    localparam int PC_CEILING = 30000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [5:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [15:0] cfg_data;

    int          fail_count;
    int          pending;
    int          stack_depth;
    int          frame_depth;
    logic [15:0] pc;
    logic [31:0] top_value;
    logic        quiet;     // no idling on either side while set

    stack_machine_executor_unit DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    smx_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .stack_depth(stack_depth),
        .frame_depth(frame_depth), .pc(pc), .top_value(top_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stall before each transfer
    initial begin
        int w;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            w = quiet ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (w - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one instruction transfer, with a random gap in front of it; returns at
    // the falling edge after the transfer so the mirrored state is current
    task automatic send(input logic [5:0] k, input logic [31:0] op);
        int g;
        g = quiet ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= op;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk) s_tvalid <= 1'b0;
    endtask

    // register write only once the block has drained
    task automatic write_length(input logic [15:0] v);
        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(negedge aclk) cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_target();
        return $urandom_range(1, PC_CEILING);
    endfunction

    // opcodes that keep the machine running from its current state
    function automatic bit runs_on(input opcode_t k);
        case (k)
            OP_NOP, OP_DUMP, OP_TRACE, OP_JMP, OP_RJMP: return 1;
            OP_CONST, OP_GLOAD, OP_JMPI, OP_RJMPI: return stack_depth < 250;
            OP_LOAD: return stack_depth < 250 && frame_depth > 0;
            OP_POP, OP_PRINT, OP_ABS, OP_NEG, OP_GSTORE, OP_JZ, OP_JNZ:
                return stack_depth >= 1;
            OP_STORE: return stack_depth >= 1 && frame_depth > 0;
            OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NEQ, OP_GT, OP_LT, OP_GTE, OP_LTE:
                return stack_depth >= 2;
            OP_DIV, OP_MOD: return stack_depth >= 2 && top_value != 0;
            OP_CALL: return frame_depth < 60;
            OP_RET: return frame_depth > 0;
            default: return 0;
        endcase
    endfunction

    task automatic run_random(input int n);
        opcode_t     k;
        logic [31:0] t;
        for (int i = 0; i < n; i++) begin
            if (pc > PC_CEILING) begin
                send(OP_JMP, rand_target());
            end else begin
                do k = opcode_t'($urandom_range(0, 32)); while (!runs_on(k));
                case (k)
                    OP_CONST: send(k, rand_word());
                    OP_GSTORE, OP_GLOAD, OP_STORE, OP_LOAD:
                        send(k, $urandom_range(0, 15));
                    OP_JMP, OP_JZ, OP_JNZ, OP_CALL: send(k, rand_target());
                    OP_RJMP: send(k, rand_target() - pc);
                    OP_JMPI: begin
                        send(OP_CONST, rand_target());
                        send(k, $urandom);
                    end
                    OP_RJMPI: begin
                        // offset is relative to the jump, which follows the push
                        t = rand_target();
                        send(OP_CONST, t - pc - 32'd2);
                        send(k, $urandom);
                    end
                    default: send(k, $urandom);
                endcase
            end
        end
    endtask

    // final instruction: one stop condition picked at random, then ignored items
    task automatic run_terminal();
        if (pc == 0) send(OP_NOP, 32'd0);
        write_length(16'd0);
        case ($urandom_range(0, 7))
            0: send(OP_JMP, 32'd0);
            1: send(OP_HALT, $urandom);
            2: send(OP_FATAL, $urandom);
            3: send(6'($urandom_range(33, 63)), $urandom);
            4: begin
                while (stack_depth > 0) send(OP_POP, 32'd0);
                send(OP_ADD, 32'd0);
            end
            5: begin
                send(OP_CONST, 32'd5);
                send(OP_CONST, 32'd0);
                send(OP_MOD, 32'd0);
            end
            6: begin
                while (frame_depth > 0) send(OP_RET, 32'd0);
                send(OP_RET, 32'd0);
            end
            default: send(OP_GLOAD, $urandom | 32'h10);
        endcase
        repeat (5) send(6'($urandom_range(0, 63)), $urandom);
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        quiet    = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        write_length(16'hFFFF);
        // directed: wrap cases of divide, sign extremes, locals and globals
        send(OP_CONST, 32'h8000_0000);
        send(OP_CONST, 32'hFFFF_FFFF);
        send(OP_DIV, 32'd0);
        send(OP_CONST, 32'h8000_0000);
        send(OP_CONST, 32'hFFFF_FFFF);
        send(OP_MOD, 32'd0);
        send(OP_ADD, 32'd0);
        send(OP_ABS, 32'd0);
        send(OP_NEG, 32'd0);
        send(OP_PRINT, 32'd0);
        send(OP_TRACE, 32'd0);
        send(OP_DUMP, 32'd0);
        send(OP_NOP, 32'hFFFF_FFFF);
        send(OP_CONST, 32'h7FFF_FFFF);
        send(OP_GSTORE, 32'd15);
        send(OP_GLOAD, 32'd15);
        send(OP_CALL, 32'd1000);
        send(OP_LOAD, 32'd15);
        send(OP_STORE, 32'd0);
        send(OP_LOAD, 32'd0);
        send(OP_RET, 32'd0);
        send(OP_GTE, 32'd0);
        send(OP_JNZ, 32'd500);
        send(OP_RJMP, 32'hFFFF_FFF6);

        // random phases, each after the first behind a drained pause and a new length
        for (int p = 0; p < 5; p++) begin
            if (p > 0) write_length(p == 4 ? 16'hFFFF : 16'($urandom_range(31000, 65534)));
            quiet = (p == 2);
            run_random(245);
        end
        quiet = 1'b0;
        run_terminal();

        @(negedge aclk) s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### files.f
design/smx_pkg.sv
design/smx_ram.sv
design/smx_div.sv
design/smx_ctrl.sv
design/smx_datapath.sv
design/stack_machine_executor_unit.sv
dv/smx_checker.sv
dv/tb_stack_machine_executor_unit.sv
